@@ rtl/core/rms_db_level_meter_top_defines.svh @@
// Assertion helpers shared by the level meter RTL.
// Each macro expects clk and rst_n in scope.
`ifndef RMS_DB_LEVEL_METER_TOP_DEFINES_SVH
`define RMS_DB_LEVEL_METER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RDLM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RDLM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rdlm_pkg.sv @@
package rdlm_pkg;

  // Frame limits and accumulator widths
  localparam int unsigned MAX_FRAME_SAMPLES = 8192;
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned SQ_W     = 32;
  localparam int unsigned CNT_W    = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int unsigned ENERGY_W = 30 + CNT_W;
  localparam int unsigned LVL_W    = 16;

  // Mean square is Q1.30, at most 2^30
  localparam int unsigned MS_W       = 31;
  localparam int unsigned DIV_CNT_W  = $clog2(ENERGY_W);
  localparam int unsigned EXP_W      = $clog2(MS_W);
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned FRAC_CNT_W = $clog2(FRAC_W);
  localparam logic [MS_W-1:0] MS_ONE = MS_W'(1) << (MS_W - 1);

  // log2 to normalized dB scaling: round(2^20*log10(2)/4)
  localparam int unsigned LOG_SCALE   = 78913;
  localparam int unsigned SCALE_W     = 17;
  localparam int unsigned LOG_SHIFT   = 20;
  localparam int unsigned N_W         = EXP_W + FRAC_W;
  localparam int unsigned PROD_W      = N_W + SCALE_W;
  localparam int unsigned DROP_W      = PROD_W - LOG_SHIFT;
  localparam int unsigned LOG_ROUND   = 1 << (LOG_SHIFT - 1);
  localparam int unsigned LEVEL_UNITY = 1 << LVL_W;

  // Smoothing weights, Q0.16
  localparam int unsigned W_NEW     = 6554;
  localparam int unsigned W_OLD     = 58982;
  localparam int unsigned MIX_W     = 2 * LVL_W + 1;
  localparam int unsigned MIX_ROUND = 1 << (LVL_W - 1);

  // Frame queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    last;
  } rdlm_in_t;

  typedef struct packed {
    logic [LVL_W-1:0] frame_level;
    logic [LVL_W-1:0] smoothed_level;
  } rdlm_out_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [CNT_W-1:0]    count;
  } rdlm_frame_t;

endpackage

@@ rtl/core/rms_db_level_meter_top.sv @@
// Frame RMS level meter with smoothed output, normalized dB scale.
// Input channel in_valid/in_ready/in_data: one signed Q1.15 sample per beat;
// in_data.last closes the frame. Samples beyond MAX_FRAME_SAMPLES in a frame
// are ignored, but a last beat still closes it.
// Result channel out_valid/out_ready/out_data: one beat per closed frame with
// frame_level and smoothed_level, both Q0.16 with 65535 for full scale.
// Input takes one sample per cycle outside the stall below; an accepted
// closing beat is registered in the square stage, then offered to the queue.
// The back part works one frame at a time: a bit-serial restoring divide, a
// normalize shift, repeated squaring for the log fraction, then the drop,
// level, mix1 and mix2 steps; a silent frame goes from the divide straight to
// the blend, and the published result is held in a registered output.
// A two-frame queue decouples the parts; the input stalls only when the
// queue is full and a closing beat waits in the square stage to enter it.
// A stalled receiver holds the result register; the back part then waits
// with its next result finished, and the queue and front keep filling.
// Reset clears the frame sums, the queue and the smoothed level.
module rms_db_level_meter_top import rdlm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rdlm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output rdlm_out_t out_data
);

  logic        push_valid, push_ready;
  rdlm_frame_t push_data;
  logic        pop_valid, pop_ready;
  rdlm_frame_t pop_data;

  rdlm_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rdlm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rdlm_level u_level (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/rdlm_accum.sv @@
`include "rms_db_level_meter_top_defines.svh"

module rdlm_accum import rdlm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  rdlm_in_t    in_data,
  output logic        push_valid,
  input  logic        push_ready,
  output rdlm_frame_t push_data
);

  logic [SMP_W-1:0]    mag;
  logic [SQ_W-1:0]     sq;
  logic                sq_vld_r, sq_vld_nxt;
  logic [SQ_W-1:0]     sq_r;
  logic                sq_last_r;
  logic [ENERGY_W-1:0] energy_r, energy_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                take;
  logic [ENERGY_W-1:0] sum_new;
  logic [CNT_W-1:0]    cnt_new;
  logic                b_stall, b_adv, in_acc;

  // Square the magnitude of the incoming beat
  assign mag = in_data.sample[SMP_W-1] ? SMP_W'(-in_data.sample) : SMP_W'(in_data.sample);
  assign sq  = SQ_W'(mag) * SQ_W'(mag);

  // Accumulate stage stalls only when a closing beat finds the queue full
  assign b_stall  = sq_vld_r && sq_last_r && !push_ready;
  assign b_adv    = sq_vld_r && !b_stall;
  assign in_ready = !sq_vld_r || !b_stall;
  assign in_acc   = in_valid && in_ready;

  // Drop samples beyond the frame limit
  assign take    = cnt_r < CNT_W'(MAX_FRAME_SAMPLES);
  assign sum_new = take ? energy_r + ENERGY_W'(sq_r) : energy_r;
  assign cnt_new = take ? cnt_r + CNT_W'(1) : cnt_r;

  assign push_valid       = sq_vld_r && sq_last_r;
  assign push_data.energy = sum_new;
  assign push_data.count  = cnt_new;

  always_comb begin
    sq_vld_nxt = sq_vld_r;
    if (in_acc) begin
      sq_vld_nxt = 1'b1;
    end else if (b_adv) begin
      sq_vld_nxt = 1'b0;
    end
  end

  // Close the frame on the last beat, otherwise keep summing
  always_comb begin
    energy_nxt = energy_r;
    cnt_nxt    = cnt_r;
    if (b_adv) begin
      if (sq_last_r) begin
        energy_nxt = '0;
        cnt_nxt    = '0;
      end else begin
        energy_nxt = sum_new;
        cnt_nxt    = cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      energy_r <= '0;
      cnt_r    <= '0;
    end else begin
      sq_vld_r <= sq_vld_nxt;
      energy_r <= energy_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold the squared beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sq_r      <= sq;
      sq_last_r <= in_data.last;
    end
  end

  `RDLM_ASSERT_IMPL(a_cnt_limit, 1'b1, cnt_r <= CNT_W'(MAX_FRAME_SAMPLES), "frame count over limit")
  `RDLM_ASSERT_IMPL(a_energy_bound, 1'b1, (energy_r >> 30) <= ENERGY_W'(cnt_r), "energy over bound")
  `RDLM_ASSERT_IMPL(a_push_count, push_valid, push_data.count != '0, "closed frame has no samples")

endmodule

@@ rtl/core/rdlm_fifo.sv @@
module rdlm_fifo import rdlm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  rdlm_frame_t push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output rdlm_frame_t pop_data
);

  rdlm_frame_t           mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  push, pop;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    ptr_inc = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
  endfunction

  assign push_ready = cnt_r != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/rdlm_level.sv @@
`include "rms_db_level_meter_top_defines.svh"

module rdlm_level import rdlm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  rdlm_frame_t pop_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rdlm_out_t   out_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_NORM  = 3'd2;
  localparam logic [2:0] ST_SQR   = 3'd3;
  localparam logic [2:0] ST_DROP  = 3'd4;
  localparam logic [2:0] ST_LEVEL = 3'd5;
  localparam logic [2:0] ST_MIX1  = 3'd6;
  localparam logic [2:0] ST_MIX2  = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [ENERGY_W-1:0]   dq_r, dq_nxt;
  logic [CNT_W-1:0]      div_r, div_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]  step_r, step_nxt;
  logic [MS_W-1:0]       x_r, x_nxt;
  logic [EXP_W-1:0]      shift_r, shift_nxt;
  logic [FRAC_W-1:0]     frac_r, frac_nxt;
  logic [FRAC_CNT_W-1:0] bit_r, bit_nxt;
  logic [DROP_W-1:0]     drop_r, drop_nxt;
  logic [LVL_W-1:0]      lvl_r, lvl_nxt;
  logic [MIX_W-1:0]      mix_r, mix_nxt;
  logic [LVL_W-1:0]      avg_r, avg_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rdlm_out_t             out_data_r;

  logic [CNT_W:0]        rem_sh;
  logic                  rem_ge;
  logic [2*MS_W-1:0]     sq_prod;
  logic [MS_W:0]         sq_top;
  logic [N_W-1:0]        n_val;
  logic [PROD_W-1:0]     drop_sum;
  logic [DROP_W-1:0]     lv_full;
  logic [MIX_W-1:0]      mix_sum;
  logic [LVL_W-1:0]      avg_new;
  logic                  slot_free, emit;

  // One restoring divide step: quotient bits shift in as dividend bits shift out
  assign rem_sh = {rem_r, dq_r[ENERGY_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_r};

  // Square the normalized mantissa, Q1.30
  assign sq_prod = (2*MS_W)'(x_r) * (2*MS_W)'(x_r);
  assign sq_top  = sq_prod[2*MS_W-1:MS_W-1];

  // Negated log2 in Q16, clamped at zero
  assign n_val    = (shift_r == '0) ? '0 : {shift_r, FRAC_W'(0)} - N_W'(frac_r);
  assign drop_sum = PROD_W'(n_val) * PROD_W'(LOG_SCALE) + PROD_W'(LOG_ROUND);
  assign lv_full  = DROP_W'(LEVEL_UNITY) - drop_r;

  // Blend new level into the running average
  assign mix_sum = mix_r + MIX_W'(W_OLD) * MIX_W'(avg_r) + MIX_W'(MIX_ROUND);
  assign avg_new = (mix_sum[MIX_W-1:2*LVL_W] != '0) ? '1 : mix_sum[2*LVL_W-1:LVL_W];

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = (state_r == ST_MIX2) && slot_free;
  assign pop_ready = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    dq_nxt    = dq_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    x_nxt     = x_r;
    shift_nxt = shift_r;
    frac_nxt  = frac_r;
    bit_nxt   = bit_r;
    drop_nxt  = drop_r;
    lvl_nxt   = lvl_r;
    mix_nxt   = mix_r;
    avg_nxt   = avg_r;
    case (state_r)
      ST_IDLE: begin
        // Take the next closed frame
        if (pop_valid) begin
          dq_nxt   = pop_data.energy;
          div_nxt  = pop_data.count;
          rem_nxt  = '0;
          step_nxt = '0;
          if (pop_data.count != '0) begin
            state_nxt = ST_DIV;
          end else begin
            lvl_nxt   = '0;
            state_nxt = ST_MIX1;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = rem_ge ? CNT_W'(rem_sh - {1'b0, div_r}) : CNT_W'(rem_sh);
        dq_nxt   = {dq_r[ENERGY_W-2:0], rem_ge};
        step_nxt = step_r + DIV_CNT_W'(1);
        if (step_r == DIV_CNT_W'(ENERGY_W - 1)) begin
          // Silence gives level zero; otherwise clamp mean square to 1.0
          if (dq_nxt == '0) begin
            lvl_nxt   = '0;
            state_nxt = ST_MIX1;
          end else begin
            x_nxt     = (dq_nxt > ENERGY_W'(MS_ONE)) ? MS_ONE : dq_nxt[MS_W-1:0];
            shift_nxt = '0;
            state_nxt = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        // Shift left until the top bit is set
        if (x_r[MS_W-1]) begin
          frac_nxt  = '0;
          bit_nxt   = '0;
          state_nxt = ST_SQR;
        end else begin
          x_nxt     = {x_r[MS_W-2:0], 1'b0};
          shift_nxt = shift_r + EXP_W'(1);
        end
      end
      ST_SQR: begin
        // One fraction bit of log2 per squaring
        if (sq_top[MS_W]) begin
          x_nxt = sq_top[MS_W:1];
        end else begin
          x_nxt = sq_top[MS_W-1:0];
        end
        frac_nxt = {frac_r[FRAC_W-2:0], sq_top[MS_W]};
        bit_nxt  = bit_r + FRAC_CNT_W'(1);
        if (bit_r == FRAC_CNT_W'(FRAC_W - 1)) begin
          state_nxt = ST_DROP;
        end
      end
      ST_DROP: begin
        drop_nxt  = drop_sum[PROD_W-1:LOG_SHIFT];
        state_nxt = ST_LEVEL;
      end
      ST_LEVEL: begin
        // Saturate at full scale and at zero
        if (drop_r == '0) begin
          lvl_nxt = '1;
        end else if (drop_r > DROP_W'(LEVEL_UNITY)) begin
          lvl_nxt = '0;
        end else begin
          lvl_nxt = lv_full[LVL_W-1:0];
        end
        state_nxt = ST_MIX1;
      end
      ST_MIX1: begin
        mix_nxt   = MIX_W'(W_NEW) * MIX_W'(lvl_r);
        state_nxt = ST_MIX2;
      end
      ST_MIX2: begin
        // Wait for the result slot, then publish
        if (slot_free) begin
          avg_nxt   = avg_new;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      shift_r     <= '0;
      bit_r       <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      shift_r     <= shift_nxt;
      bit_r       <= bit_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    dq_r   <= dq_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    x_r    <= x_nxt;
    frac_r <= frac_nxt;
    drop_r <= drop_nxt;
    lvl_r  <= lvl_nxt;
    mix_r  <= mix_nxt;
    if (emit) begin
      out_data_r.frame_level    <= lvl_r;
      out_data_r.smoothed_level <= avg_new;
    end
  end

  `RDLM_ASSERT_IMPL(a_div_rem, state_r == ST_DIV, rem_r < div_r, "remainder not below divisor")
  `RDLM_ASSERT_IMPL(a_sqr_norm, state_r == ST_SQR, x_r[MS_W-1], "mantissa not normalized")
  `RDLM_ASSERT_NEXT(a_emit, emit, out_valid_r && state_r == ST_IDLE, "result not published")

endmodule
